// ===== rtl/core/twp_pkg.sv =====
// ----------------------------------------------------------------------------
// twp_pkg: shared types and helpers for the telemetry window packer
// Record layout, action codes, controller commands and the quantizer.
// ----------------------------------------------------------------------------
package twp_pkg;

	localparam int REC_BITS       = 57;
	localparam int WINDOW_DEFAULT = 32;

	typedef enum logic [1:0] {
		ACT_INIT = 2'd0,
		ACT_PUSH = 2'd1,
		ACT_GET  = 2'd2,
		ACT_BYTE = 2'd3
	} action_t;

	// controller -> datapath
	typedef struct packed {
		logic    capture;   // latch input transaction
		logic    clr_step;  // clear one store entry
		logic    execute;   // apply action, build result
		logic    rd_step;   // one byte-read bit step
		logic    out_load;  // load output register
	} twp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic    is_init;
		logic    is_byte;
		logic    clr_done;
		logic    rd_done;
	} twp_sts_t;

	// floor(t/256) clamped to 0..255
	function automatic logic [7:0] quant(input logic signed [23:0] t);
		logic signed [15:0] q;
		q = 16'(t >>> 8);
		if (q < 0) return 8'd0;
		else if (q > 16'sd255) return 8'd255;
		else return q[7:0];
	endfunction

endpackage

// ===== rtl/core/twp_ctrl.sv =====
// ----------------------------------------------------------------------------
// twp_ctrl: sequencer for the telemetry window packer
// Takes a transaction, runs clear or byte-read passes, loads the output.
// ----------------------------------------------------------------------------
module twp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_free,
	input  twp_pkg::twp_sts_t sts,
	output logic              in_ready,
	output twp_pkg::twp_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_CLEAR = 5'b00100,
		ST_READ  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_fire;
				if (in_fire) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
				if (sts.is_init) state_d = ST_CLEAR;
				else if (sts.is_byte) state_d = ST_READ;
				else state_d = ST_OUT;
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_OUT;
			end
			ST_READ: begin
				cmd.rd_step = 1'b1;
				if (sts.rd_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/twp_datapath.sv =====
// ----------------------------------------------------------------------------
// twp_datapath: record store, ring pointer, quantizers, byte extraction
// Store is a memory with one registered read port; byte reads take 8 bit steps after a prime.
// ----------------------------------------------------------------------------
module twp_datapath #(
	parameter int WINDOW_RECORDS = twp_pkg::WINDOW_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  twp_pkg::twp_cmd_t cmd,
	output twp_pkg::twp_sts_t sts,
	input  logic [1:0]        action,
	input  logic [31:0]       start_time,
	input  logic [31:0]       time_step,
	input  logic              mode_flag,
	input  logic [15:0]       battery_voltage,
	input  logic [15:0]       battery_current,
	input  logic [15:0]       rail3v3_current,
	input  logic [15:0]       rail5v_current,
	input  logic [15:0]       radio_temperature,
	input  logic [15:0]       power_temperature,
	input  logic [15:0]       battery_temperature,
	input  logic [7:0]        item_index,
	output logic [56:0]       res_rec,
	output logic [8:0]        res_count,
	output logic [31:0]       res_time,
	output logic [7:0]        res_bytes,
	output logic [7:0]        res_pbyte
);

	localparam int AW = (WINDOW_RECORDS > 1) ? $clog2(WINDOW_RECORDS) : 1;
	localparam int CW = $clog2(WINDOW_RECORDS + 1);
	localparam int RB = twp_pkg::REC_BITS;

	logic [RB-1:0] mem [WINDOW_RECORDS];
	logic [RB-1:0] rd_data_q;
	logic [AW-1:0] oldest_q, clr_q;
	logic [CW-1:0] count_q;
	logic [31:0]   time_q;

	logic [1:0]  act_q;
	logic [31:0] start_q, step_q;
	logic [7:0]  idx_q;
	logic [56:0] prec_q;
	logic [56:0] rec_q;
	logic [2:0]  bit_q;
	logic [5:0]  off_q;      // offset within record
	logic [7:0]  rk_q;       // record number
	logic        rd_wait_q;  // first read step primes memory
	logic [7:0]  pbyte_q;

	// quantized record from inputs
	logic [56:0] new_rec;
	always_comb begin
		new_rec = {mode_flag,
			twp_pkg::quant(24'($signed(battery_voltage)) * 24'sd20 - 24'sd15360),
			twp_pkg::quant(24'($signed(battery_current)) * 24'sd127 + 24'sd32512),
			twp_pkg::quant(24'($signed(rail3v3_current)) * 24'sd40),
			twp_pkg::quant(24'($signed(rail5v_current)) * 24'sd40),
			twp_pkg::quant(24'($signed(radio_temperature)) * 24'sd4 + 24'sd15360),
			twp_pkg::quant(24'($signed(power_temperature)) * 24'sd4 + 24'sd15360),
			twp_pkg::quant(24'($signed(battery_temperature)) * 24'sd4 + 24'sd15360)};
	end

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] b, input logic [8:0] k);
		logic [9:0] s;
		s = 10'(b) + 10'(k);
		if (s >= 10'(WINDOW_RECORDS)) s = s - 10'(WINDOW_RECORDS);
		return s[AW-1:0];
	endfunction

	logic          full;
	logic [AW-1:0] wr_slot, rd_addr;
	logic          wr_en;
	assign full = (count_q == CW'(WINDOW_RECORDS));
	assign wr_slot = full ? oldest_q : slot_of(oldest_q, 9'(count_q));

	always_comb begin
		if (cmd.rd_step) rd_addr = slot_of(oldest_q, {1'b0, rk_q});
		else rd_addr = slot_of(oldest_q, {1'b0, idx_q});
	end

	assign wr_en = cmd.clr_step || (cmd.execute && act_q == twp_pkg::ACT_PUSH);

	always_ff @(posedge clk) begin
		if (wr_en) mem[cmd.clr_step ? clr_q : wr_slot] <= cmd.clr_step ? '0 : prec_q;
		rd_data_q <= mem[rd_addr];
	end

	assign sts.is_init  = (act_q == twp_pkg::ACT_INIT);
	assign sts.is_byte  = (act_q == twp_pkg::ACT_BYTE);
	assign sts.clr_done = (clr_q == AW'(WINDOW_RECORDS - 1));
	assign sts.rd_done  = !rd_wait_q && bit_q == 3'd7;

	// payload capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= action;
			start_q <= start_time;
			step_q  <= time_step;
			idx_q   <= item_index;
			prec_q  <= new_rec;
			off_q   <= '0;
			rk_q    <= '0;
		end
		if (cmd.execute) begin
			// find record number and offset of first bit: at most 35 subtracts
			// unrolled is too deep; divide by 57 via reciprocal multiply and shift
			rk_q  <= 8'((22'({idx_q, 3'd0}) * 22'd1150) >> 16);
			off_q <= 6'(11'({idx_q, 3'd0}) - 11'(
				11'((22'({idx_q, 3'd0}) * 22'd1150) >> 16) * 11'd57));
			rec_q <= (act_q == twp_pkg::ACT_PUSH) ? prec_q : '0;
		end
		if (cmd.rd_step && !rd_wait_q) begin
			if (off_q == 6'd56) begin
				off_q <= '0;
				rk_q  <= rk_q + 8'd1;
			end else begin
				off_q <= off_q + 6'd1;
			end
			pbyte_q <= {pbyte_q[6:0],
				(9'(rk_q) < 9'(count_q)) ? rd_data_q[6'd56 - off_q] : 1'b0};
		end
		if (cmd.execute) pbyte_q <= '0;
	end

	// get: the read at execute time returns data in the next cycle (ST_OUT)
	logic get_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q  <= '0;
			count_q   <= '0;
			time_q    <= '0;
			clr_q     <= '0;
			bit_q     <= '0;
			rd_wait_q <= 1'b1;
			get_q     <= 1'b0;
		end else begin
			if (cmd.execute) begin
				get_q     <= (act_q == twp_pkg::ACT_GET) && (9'(idx_q) < 9'(count_q));
				rd_wait_q <= 1'b1;
				bit_q     <= '0;
				clr_q     <= '0;
				case (act_q)
					twp_pkg::ACT_INIT: begin
						oldest_q <= '0;
						count_q  <= '0;
						time_q   <= start_q;
					end
					twp_pkg::ACT_PUSH: begin
						if (full) begin
							oldest_q <= (oldest_q == AW'(WINDOW_RECORDS - 1)) ? '0
								: oldest_q + AW'(1);
							time_q   <= time_q + step_q;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
					default: ;
				endcase
			end
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.rd_step) begin
				if (rd_wait_q) rd_wait_q <= 1'b0;
				else begin
					bit_q     <= bit_q + 3'd1;
					rd_wait_q <= (off_q == 6'd56);
				end
			end
		end
	end

	logic [14:0] bits_total;
	assign bits_total = 15'(count_q) * 15'd57 + 15'd7;
	assign res_rec   = get_q ? rd_data_q : rec_q;
	assign res_count = 9'(count_q);
	assign res_time  = time_q;
	assign res_bytes = 8'(15'd4 + (bits_total >> 3));
	assign res_pbyte = pbyte_q;

endmodule

// ===== rtl/core/telemetry_window_packer.sv =====
// ----------------------------------------------------------------------------
// telemetry_window_packer: sliding window of 57-bit telemetry records
// Accept to m_tvalid: push/get go through execute and output load; init adds
// one clear step per store entry; a packed byte read adds a memory prime,
// eight bit steps and one more prime if the byte crosses a record.
// One transaction at a time: s_tready returns the cycle after the result is
// loaded into the output register.
// Reset (arst_n low, asynchronous) empties the window and zeroes window time;
// store entries not covered by the count read as zero.
// ----------------------------------------------------------------------------
module telemetry_window_packer #(
	parameter int WINDOW_RECORDS = twp_pkg::WINDOW_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: action[1:0], start_time, time_step, mode_flag, battery_voltage,
	// battery_current, rail3v3_current, rail5v_current, radio_temperature,
	// power_temperature, battery_temperature, item_index; zero pad to 192
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: mode_out, voltage, current, rail3v3, rail5v, radio_temp,
	// power_temp, battery_temp codes, records_held[5:0], window_time,
	// stream_bytes, packed_byte; zero pad to 112
	output logic [111:0] m_tdata
);

	twp_pkg::twp_cmd_t cmd;
	twp_pkg::twp_sts_t sts;
	logic        in_fire;
	logic [56:0] res_rec;
	logic [8:0]  res_count;
	logic [31:0] res_time;
	logic [7:0]  res_bytes, res_pbyte;
	logic        out_free;

	assign in_fire  = s_tvalid && s_tready;
	// output register frees when empty or being taken this cycle
	assign out_free = !m_tvalid || m_tready;

	twp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	twp_datapath #(.WINDOW_RECORDS(WINDOW_RECORDS)) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.action              (s_tdata[1:0]),
		.start_time          (s_tdata[33:2]),
		.time_step           (s_tdata[65:34]),
		.mode_flag           (s_tdata[66]),
		.battery_voltage     (s_tdata[82:67]),
		.battery_current     (s_tdata[98:83]),
		.rail3v3_current     (s_tdata[114:99]),
		.rail5v_current      (s_tdata[130:115]),
		.radio_temperature   (s_tdata[146:131]),
		.power_temperature   (s_tdata[162:147]),
		.battery_temperature (s_tdata[178:163]),
		.item_index          (s_tdata[186:179]),
		.res_rec             (res_rec),
		.res_count           (res_count),
		.res_time            (res_time),
		.res_bytes           (res_bytes),
		.res_pbyte           (res_pbyte)
	);

	// output register: record fields low-first in the bus order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (cmd.out_load) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			m_tdata <= {1'b0, res_pbyte, res_bytes, res_time, res_count[5:0],
				res_rec[7:0], res_rec[15:8], res_rec[23:16], res_rec[31:24],
				res_rec[39:32], res_rec[47:40], res_rec[55:48], res_rec[56]};
	end

	// no new transaction while a result is pending in the controller
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("input taken while busy");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("output overwritten");

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for telemetry_window_packer
// Drives random and directed init/push/get/byte-read transactions with
// random gaps and backpressure; a scoreboard predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int NREC = 32;

	typedef struct packed {
		logic [7:0]  idx;
		logic [15:0] tb, te, tc, r5, r3, a, v;
		logic        mode;
		logic [31:0] dt, t0;
		logic [1:0]  act;
	} req_t;

	typedef struct packed {
		logic [7:0]  pbyte;
		logic [7:0]  nbytes;
		logic [31:0] wtime;
		logic [5:0]  held;
		logic [7:0]  c6, c5, c4, c3, c2, c1, c0;
		logic        mode;
	} rsp_t;

	class window_scoreboard;
		logic [56:0] store [NREC];
		int unsigned head, count;
		logic [31:0] wtime;
		rsp_t pending [$];
		int errors, checked;

		function new();
			foreach (store[i]) store[i] = '0;
			head = 0; count = 0; wtime = 0; errors = 0; checked = 0;
		endfunction

		function logic [7:0] code_of(int t);
			int q;
			q = (t >= 0) ? t / 256 : -((-t + 255) / 256);
			if (q < 0) return 8'd0;
			if (q > 255) return 8'd255;
			return q[7:0];
		endfunction

		function logic [56:0] logical(int unsigned k);
			if (k >= count) return '0;
			return store[(head + k) % NREC];
		endfunction

		function void note_input(req_t r);
			logic [56:0] rec;
			logic [7:0] pb;
			rsp_t e;
			int unsigned p;
			rec = '0; pb = '0;
			case (twp_pkg::action_t'(r.act))
				twp_pkg::ACT_INIT: begin
					foreach (store[i]) store[i] = '0;
					head = 0; count = 0; wtime = r.t0;
				end
				twp_pkg::ACT_PUSH: begin
					rec[56] = r.mode;
					rec[55:48] = code_of(20 * $signed(r.v) - 60 * 256);
					rec[47:40] = code_of(127 * $signed(r.a) + 127 * 256);
					rec[39:32] = code_of(40 * $signed(r.r3));
					rec[31:24] = code_of(40 * $signed(r.r5));
					rec[23:16] = code_of(4 * $signed(r.tc) + 60 * 256);
					rec[15:8] = code_of(4 * $signed(r.te) + 60 * 256);
					rec[7:0] = code_of(4 * $signed(r.tb) + 60 * 256);
					if (count < NREC) begin
						store[(head + count) % NREC] = rec;
						count++;
					end else begin
						store[head] = rec;
						head = (head + 1) % NREC;
						wtime += r.dt;
					end
				end
				twp_pkg::ACT_GET: rec = logical(r.idx);
				default: begin
					for (int q = 0; q < 8; q++) begin
						logic [56:0] lr;
						p = r.idx * 8 + q;
						lr = logical(p / 57);
						pb = {pb[6:0], lr[56 - (p % 57)]};
					end
				end
			endcase
			if (r.act == twp_pkg::ACT_INIT || r.act == twp_pkg::ACT_BYTE) rec = '0;
			e = '0;
			{e.mode, e.c0, e.c1, e.c2, e.c3, e.c4, e.c5, e.c6} = rec;
			e.held = count[5:0];
			e.wtime = wtime;
			e.nbytes = 8'(4 + (57 * count + 7) / 8);
			e.pbyte = pb;
			pending.push_back(e);
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.mode !== e.mode) report("mode_out", e.mode, got.mode);
			if (got.c0 !== e.c0) report("voltage_code", e.c0, got.c0);
			if (got.c1 !== e.c1) report("current_code", e.c1, got.c1);
			if (got.c2 !== e.c2) report("rail3v3_code", e.c2, got.c2);
			if (got.c3 !== e.c3) report("rail5v_code", e.c3, got.c3);
			if (got.c4 !== e.c4) report("radio_temp_code", e.c4, got.c4);
			if (got.c5 !== e.c5) report("power_temp_code", e.c5, got.c5);
			if (got.c6 !== e.c6) report("battery_temp_code", e.c6, got.c6);
			if (got.held !== e.held) report("records_held", e.held, got.held);
			if (got.wtime !== e.wtime) report("window_time", e.wtime, got.wtime);
			if (got.nbytes !== e.nbytes) report("stream_bytes", e.nbytes, got.nbytes);
			if (got.pbyte !== e.pbyte) report("packed_byte", e.pbyte, got.pbyte);
		endfunction

		function void report(string f, logic [31:0] e, logic [31:0] g);
			$display("%0t: %s expected %h actual %h", $time, f, e, g);
			errors++;
		endfunction
	endclass

	logic clk, arst_n, s_tvalid, s_tready, m_tvalid, m_tready;
	logic [191:0] s_tdata;
	logic [111:0] m_tdata;
	window_scoreboard sb;
	int n_push, n_byte;

	telemetry_window_packer DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("status: fail");
		$finish;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: short random stalls, now and then a long one
	initial begin
		m_tready = 0;
		@(negedge clk);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 49) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end
			m_tready <= ($urandom_range(0, 9) < 7);
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_result(rsp_t'(m_tdata[110:0]));

	function automatic logic [15:0] sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(($urandom_range(0, 2000)) - 1000);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic req_t make_req(twp_pkg::action_t a);
		req_t r;
		r = '0;
		r.act = a;
		r.t0 = $urandom; r.dt = $urandom; r.mode = 1'($urandom);
		r.v = sample(); r.a = sample(); r.r3 = sample(); r.r5 = sample();
		r.tc = sample(); r.te = sample(); r.tb = sample();
		r.idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
			(a == twp_pkg::ACT_GET ? 8'($urandom_range(0, 33)) :
			8'($urandom_range(0, 230)));
		return r;
	endfunction

	// valid stays high across back-to-back transactions; drops only for a gap or in drain
	task automatic send(req_t r);
		int g;
		g = gap_len();
		@(negedge clk);
		if (g != 0) begin
			s_tvalid <= 0;
			repeat (g) @(negedge clk);
		end
		s_tdata <= 192'(r);
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		sb.note_input(r);
		if (r.act == twp_pkg::ACT_PUSH) n_push++;
		if (r.act == twp_pkg::ACT_BYTE) n_byte++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(negedge clk);
	endtask

	initial begin
		req_t r;
		sb = new();
		n_push = 0; n_byte = 0;
		arst_n = 0; s_tvalid = 0; s_tdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reads on an empty window, extremes, overflow of the ring
		r = make_req(twp_pkg::ACT_GET); r.idx = 0; send(r);
		r = make_req(twp_pkg::ACT_BYTE); r.idx = 0; send(r);
		r = make_req(twp_pkg::ACT_INIT); r.t0 = 32'hffff_fff0; send(r);
		r = make_req(twp_pkg::ACT_PUSH);
		{r.v, r.a, r.r3, r.r5, r.tc, r.te, r.tb} = {7{16'h7fff}}; r.mode = 1;
		send(r);
		r = make_req(twp_pkg::ACT_PUSH);
		{r.v, r.a, r.r3, r.r5, r.tc, r.te, r.tb} = {7{16'h8000}}; r.mode = 0;
		send(r);
		r = make_req(twp_pkg::ACT_GET); r.idx = 1; send(r);
		r = make_req(twp_pkg::ACT_GET); r.idx = 2; send(r);
		r = make_req(twp_pkg::ACT_BYTE); r.idx = 7; send(r);
		r = make_req(twp_pkg::ACT_BYTE); r.idx = 255; send(r);
		for (int i = 0; i < 34; i++) begin
			r = make_req(twp_pkg::ACT_PUSH); r.dt = 32'hffff_ffff; send(r);
		end
		r = make_req(twp_pkg::ACT_GET); r.idx = 31; send(r);
		r = make_req(twp_pkg::ACT_BYTE); r.idx = 227; send(r);
		r = make_req(twp_pkg::ACT_BYTE); r.idx = 228; send(r);
		drain();

		for (int i = 0; i < 1500; i++) begin
			int sel;
			sel = $urandom_range(0, 99);
			if (sel < 2) r = make_req(twp_pkg::ACT_INIT);
			else if (sel < 45) r = make_req(twp_pkg::ACT_PUSH);
			else if (sel < 65) r = make_req(twp_pkg::ACT_GET);
			else r = make_req(twp_pkg::ACT_BYTE);
			send(r);
			if (i == 700) drain();
		end
		drain();

		$display("covered %0d results: %0d pushes, %0d byte reads, wraparound included",
			sb.checked, n_push, n_byte);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
